// File: rtl/frame_jitter_bitrate_adapter_defines.svh
// Assertion macros shared by the frame jitter bitrate adapter RTL.
`ifndef FRAME_JITTER_BITRATE_ADAPTER_DEFINES_SVH
`define FRAME_JITTER_BITRATE_ADAPTER_DEFINES_SVH

// Clocked implication check with reset disable.
`define FJBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication check with reset disable.
`define FJBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/fjba_pkg.sv
// Package with types and constants of the frame jitter bitrate adapter.
package fjba_pkg;

  localparam int unsigned MaxWindowDef = 32;
  localparam int unsigned MinWindowDef = 10;

  localparam logic [2:0] OUT_DISABLED = 3'd0;
  localparam logic [2:0] OUT_ZERO     = 3'd1;
  localparam logic [2:0] OUT_LITTLE   = 3'd2;
  localparam logic [2:0] OUT_STABLE   = 3'd3;
  localparam logic [2:0] OUT_UNSTABLE = 3'd4;

  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_MIN    = 3'd1;
  localparam logic [2:0] REG_MAX    = 3'd2;
  localparam logic [2:0] REG_THR    = 3'd3;
  localparam logic [2:0] REG_UP     = 3'd4;
  localparam logic [2:0] REG_DOWN   = 3'd5;
  localparam logic [2:0] REG_STEPS  = 3'd6;
  localparam logic [2:0] REG_START  = 3'd7;

  // Divider job: frame rate, mean or variance.
  localparam logic [1:0] DIV_FPS  = 2'd0;
  localparam logic [1:0] DIV_MEAN = 2'd1;
  localparam logic [1:0] DIV_VAR  = 2'd2;

  localparam logic [31:0] FpsNum = 32'd65536000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_GAP,
    ST_DIV,
    ST_MEAN,
    ST_VRD,
    ST_VSQ,
    ST_VDIV,
    ST_LIM,
    ST_DEC,
    ST_MUL,
    ST_APPLY,
    ST_OUT
  } state_e;

endpackage

// File: rtl/fjba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module fjba_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/frame_jitter_bitrate_adapter.sv
// Top level of the frame jitter bitrate adapter.
//
// channel | direction | handshake         | payload
// in      | input     | in_valid/in_ready | arrival_ms, packet_bytes
// out     | output    | out_valid/out_ready | rate_now, rate_changed, outcome
// cfg     | input     | cfg_we            | cfg_index, cfg_data
//
// A skipped arrival, or one that leaves fewer than 2 timestamps, has its result registered
// in the cycle after acceptance. Otherwise the result follows two window walks over the W
// timestamps, with a serial divide per valid gap in each walk; the mean divide runs
// after the first walk and the variance divide after the second. With fewer than 3 valid
// gaps, the result follows the first walk alone.
// Reset clears control state and loads register defaults. A stalled output holds
// its register; the next transaction is taken only once the result has gone.
module frame_jitter_bitrate_adapter
  import fjba_pkg::*;
#(
  parameter int unsigned MaxWindow = MaxWindowDef,
  parameter int unsigned MinWindow = MinWindowDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] arrival_ms_i,
  input  logic [23:0] packet_bytes_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] rate_now_o,
  output logic        rate_changed_o,
  output logic [2:0]  outcome_o,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  `include "frame_jitter_bitrate_adapter_defines.svh"

  localparam int unsigned AW = $clog2(MaxWindow);
  localparam int unsigned CW = $clog2(MaxWindow + 1);

  // Configuration registers.
  logic        en_q;
  logic [30:0] min_q, max_q;
  logic [15:0] thr_q, up_q, down_q;
  logic [7:0]  steps_q;

  // Control state.
  state_e           st_q, st_d;
  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [7:0]       run_q, run_d;
  logic [30:0]      rate_q, rate_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    n_q, n_d;
  logic [31:0]      prev_q, prev_d;
  logic             gok_q, gok_d;
  logic             pass_q, pass_d;
  logic [31:0]      sum_q, sum_d;
  logic [63:0]      ssq_q, ssq_d;
  logic [25:0]      mean_q, mean_d;
  // Shared restoring divider.
  logic [63:0]      rem_q, rem_d;
  logic [63:0]      quo_q, quo_d;
  logic [31:0]      dvs_q, dvs_d;
  logic [6:0]       bit_q, bit_d;
  logic [1:0]       dsel_q, dsel_d;
  logic [63:0]      lim2_q, lim2_d;
  logic [25:0]      lim_q, lim_d;
  logic [46:0]      prod_q, prod_d;
  logic             unst_q, unst_d;
  logic             raise_q, raise_d;
  logic             ovld_q, ovld_d;
  logic [30:0]      orate_q, orate_d;
  logic             ochg_q, ochg_d;
  logic [2:0]       oout_q, oout_d;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [31:0]      rdata;

  fjba_ram #(.Width(32), .Depth(MaxWindow)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(arrival_ms_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Window length.
  logic [8:0] win;
  always_comb begin
    win = {1'b0, steps_q};
    if (win < 9'(MinWindow)) win = 9'(MinWindow);
    if (win > 9'(MaxWindow)) win = 9'(MaxWindow);
  end

  logic [CW:0]   cnt_inc;
  logic [AW:0]   start_w;
  logic [AW:0]   rd_w;
  logic [31:0]   gap;
  logic          gap_ok;
  logic [64:0]   rem_sh;
  logic [64:0]   rem_sub;
  logic [25:0]   fps;
  logic [26:0]   dif;
  logic [32:0]   desired;
  logic [35:0]   diff20;

  assign in_ready  = (st_q == ST_IDLE) && !ovld_q;
  assign out_valid = ovld_q;
  assign rate_now_o     = orate_q;
  assign rate_changed_o = ochg_q;
  assign outcome_o      = oout_q;

  assign start_w = (AW+1)'(head_q) + (AW+1)'(MaxWindow) - (AW+1)'(cnt_q);
  assign rd_w    = start_w + (AW+1)'(idx_q);
  assign gap     = rdata - prev_q;
  assign gap_ok  = (gap >= 32'd2) && (gap <= 32'd9999);
  assign rem_sh  = {rem_q, quo_q[63]};
  assign rem_sub = rem_sh - {33'd0, dvs_q};
  assign fps     = quo_q[25:0];
  assign dif     = (fps >= mean_q) ? {1'b0, fps - mean_q} : {1'b0, mean_q - fps};

  // Next state, datapath and result.
  always_comb begin
    st_d = st_q; head_d = head_q; cnt_d = cnt_q; run_d = run_q; rate_d = rate_q;
    idx_d = idx_q; n_d = n_q; prev_d = prev_q; gok_d = gok_q; pass_d = pass_q;
    sum_d = sum_q;
    ssq_d = ssq_q; mean_d = mean_q; rem_d = rem_q; quo_d = quo_q; dvs_d = dvs_q;
    bit_d = bit_q; dsel_d = dsel_q; lim2_d = lim2_q; lim_d = lim_q; prod_d = prod_q;
    unst_d = unst_q; raise_d = raise_q; ovld_d = ovld_q; orate_d = orate_q;
    ochg_d = ochg_q; oout_d = oout_q;
    we = 1'b0; waddr = head_q;
    raddr = (rd_w >= (AW+1)'(MaxWindow)) ? AW'(rd_w - (AW+1)'(MaxWindow)) : AW'(rd_w);
    cnt_inc = (CW+1)'(cnt_q) + 1'b1;
    desired = '0; diff20 = '0;
    if (ovld_q && out_ready) ovld_d = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (!en_q || packet_bytes_i == '0) begin
            ovld_d = 1'b1; orate_d = rate_q; ochg_d = 1'b0;
            oout_d = en_q ? OUT_ZERO : OUT_DISABLED;
          end else begin
            we = 1'b1;
            head_d = (32'(head_q) + 1 >= MaxWindow) ? '0 : head_q + 1'b1;
            cnt_d = (cnt_inc > (CW+1)'(win)) ? CW'(win) : CW'(cnt_inc);
            if (cnt_d < CW'(2)) begin
              ovld_d = 1'b1; orate_d = rate_q; ochg_d = 1'b0; oout_d = OUT_LITTLE;
            end else begin
              idx_d = '0; n_d = '0; sum_d = '0; ssq_d = '0; pass_d = 1'b0;
              st_d = ST_RD;
            end
          end
        end
      end
      // Issue read of timestamp idx.
      ST_RD: st_d = ST_GAP;
      // Hold the gap verdict; prev takes the new timestamp.
      ST_GAP: begin
        prev_d = rdata;
        gok_d = (idx_q != '0) && gap_ok;
        if (idx_q != '0 && gap_ok) begin
          rem_d = '0; quo_d = {FpsNum, 32'd0}; dvs_d = gap; bit_d = 7'd32;
          dsel_d = DIV_FPS; st_d = ST_DIV;
        end else begin
          st_d = ST_MEAN;
        end
      end
      // One quotient bit per cycle.
      ST_DIV: begin
        if (rem_sub[64]) begin
          rem_d = rem_sh[63:0]; quo_d = {quo_q[62:0], 1'b0};
        end else begin
          rem_d = rem_sub[63:0]; quo_d = {quo_q[62:0], 1'b1};
        end
        bit_d = bit_q - 1'b1;
        if (bit_q == 7'd1) begin
          unique case (dsel_q)
            DIV_FPS:  st_d = pass_q ? ST_VSQ : ST_MEAN;
            DIV_MEAN: st_d = ST_VDIV;
            default:  st_d = ST_LIM;
          endcase
        end
      end
      // Accumulate and step; at window end form the mean, or after the second walk the variance.
      ST_MEAN: begin
        if (gok_q && !pass_q) begin
          sum_d = sum_q + 32'(fps); n_d = n_q + 1'b1;
        end
        if (idx_q + 1'b1 < cnt_q) begin
          idx_d = idx_q + 1'b1; st_d = ST_RD;
        end else if (!pass_q) begin
          if (n_d < CW'(3)) begin
            ovld_d = 1'b1; orate_d = rate_q; ochg_d = 1'b0; oout_d = OUT_LITTLE;
            st_d = ST_IDLE;
          end else begin
            rem_d = '0; quo_d = {sum_d, 32'd0}; dvs_d = 32'(n_d);
            bit_d = 7'd32; dsel_d = DIV_MEAN; pass_d = 1'b1; st_d = ST_DIV;
            // sum fits 32 bits: at most 31 * 32768000
          end
        end else begin
          rem_d = '0; quo_d = ssq_q; dvs_d = 32'(n_q); bit_d = 7'd64;
          dsel_d = DIV_VAR; st_d = ST_DIV;
        end
      end
      ST_VDIV: begin
        mean_d = quo_q[25:0]; idx_d = '0; st_d = ST_RD;
      end
      // Square the deviation.
      ST_VSQ: begin
        ssq_d = ssq_q + 64'(dif) * 64'(dif);
        st_d = ST_MEAN;
      end
      ST_LIM: begin
        lim2_d = quo_q;
        lim_d = 26'((42'(thr_q) * 42'(mean_q)) >> 16);
        st_d = ST_VRD;
      end
      ST_VRD: begin
        unst_d = lim2_q > 64'(lim_q) * 64'(lim_q); st_d = ST_DEC;
      end
      ST_DEC: begin
        raise_d = 1'b0;
        if (unst_q) begin
          prod_d = rate_q * down_q; run_d = '0;
        end else begin
          if (run_q != 8'd255) run_d = run_q + 1'b1;
          if (run_d >= steps_q) begin
            prod_d = rate_q * up_q; raise_d = 1'b1; run_d = '0;
          end else begin
            prod_d = {rate_q, 14'd0};
          end
        end
        st_d = ST_MUL;
      end
      ST_MUL: begin
        desired = prod_q[46:14];
        if (unst_q && desired < {2'b0, min_q}) desired = {2'b0, min_q};
        if (raise_q && desired > {2'b0, max_q}) desired = {2'b0, max_q};
        if (desired < {2'b0, min_q}) desired = {2'b0, min_q};
        if (desired > {2'b0, max_q}) desired = {2'b0, max_q};
        prod_d = 47'(desired);
        st_d = ST_APPLY;
      end
      ST_APPLY: begin
        desired = prod_q[32:0];
        diff20 = 36'((desired >= {2'b0, rate_q}) ? desired - {2'b0, rate_q}
                                                   : {2'b0, rate_q} - desired) * 36'd20;
        ochg_d = diff20 > 36'(rate_q);
        if (ochg_d) rate_d = desired[30:0];
        orate_d = ochg_d ? desired[30:0] : rate_q;
        oout_d = unst_q ? OUT_UNSTABLE : OUT_STABLE;
        ovld_d = 1'b1; st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
    if (cfg_we && cfg_index == REG_START) rate_d = cfg_data;
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; head_q <= '0; cnt_q <= '0; run_q <= '0; rate_q <= 31'd2000000;
      ovld_q <= 1'b0;
      en_q <= 1'b1; min_q <= 31'd500000; max_q <= 31'd8000000; thr_q <= 16'd13107;
      up_q <= 16'd18022; down_q <= 16'd13107; steps_q <= 8'd10;
    end else begin
      st_q <= st_d; head_q <= head_d; cnt_q <= cnt_d; run_q <= run_d; rate_q <= rate_d;
      ovld_q <= ovld_d;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ENABLE: en_q <= cfg_data[0];
          REG_MIN:    min_q <= cfg_data;
          REG_MAX:    max_q <= cfg_data;
          REG_THR:    thr_q <= cfg_data[15:0];
          REG_UP:     up_q <= cfg_data[15:0];
          REG_DOWN:   down_q <= cfg_data[15:0];
          REG_STEPS:  steps_q <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; n_q <= n_d; prev_q <= prev_d; gok_q <= gok_d; pass_q <= pass_d;
    sum_q <= sum_d;
    ssq_q <= ssq_d; mean_q <= mean_d; rem_q <= rem_d; quo_q <= quo_d; dvs_q <= dvs_d;
    bit_q <= bit_d; dsel_q <= dsel_d; lim2_q <= lim2_d; lim_q <= lim_d;
    prod_q <= prod_d; unst_q <= unst_d; raise_q <= raise_d; orate_q <= orate_d;
    ochg_q <= ochg_d; oout_q <= oout_d;
  end

  `FJBA_ASSERT_IMP(a_no_take_busy, clk_i, rst_ni, st_q != ST_IDLE, !in_ready)
  `FJBA_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CW'(MaxWindow))
  `FJBA_ASSERT_NEXT(a_chg_out, clk_i, rst_ni, st_q == ST_APPLY, out_valid)

endmodule

// File: tb/frame_jitter_bitrate_adapter_tb.sv
// Self-checking testbench for the frame jitter bitrate adapter.
module frame_jitter_bitrate_adapter_tb
  import fjba_pkg::*;
();

  localparam int unsigned WinCap = 32;
  localparam longint unsigned CycleLimit = 20000000;

  typedef struct packed {
    logic [31:0] arrival_ms;
    logic [23:0] packet_bytes;
  } arrival_t;

  typedef struct packed {
    logic [30:0] rate_now;
    logic        rate_changed;
    logic [2:0]  outcome;
  } rate_report_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] arrival_ms_i;
  logic [23:0] packet_bytes_i;
  logic        out_valid;
  logic        out_ready;
  logic [30:0] rate_now_o;
  logic        rate_changed_o;
  logic [2:0]  outcome_o;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [30:0] cfg_data;

  frame_jitter_bitrate_adapter dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid(in_valid), .in_ready(in_ready),
    .arrival_ms_i(arrival_ms_i), .packet_bytes_i(packet_bytes_i),
    .out_valid(out_valid), .out_ready(out_ready),
    .rate_now_o(rate_now_o), .rate_changed_o(rate_changed_o), .outcome_o(outcome_o),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the block's registers and state
  logic        enable_q;
  logic [30:0] min_q, max_q, rate_q;
  logic [15:0] thr_q, up_q, down_q;
  logic [7:0]  steps_q, run_q;
  logic [31:0] stamp_ring [WinCap];
  int unsigned stamp_count, ring_head;

  arrival_t     pending_arrivals[$];
  rate_report_t expected_reports[$];
  int           failures;
  longint unsigned cycle_count;
  int           send_wait, recv_wait;
  logic         arm_dwell;
  logic [31:0]  last_stamp;

  // Append one arrival to the pending queue
  function automatic void add_arrival(logic [31:0] t, logic [23:0] b);
    arrival_t a;
    a.arrival_ms = t;
    a.packet_bytes = b;
    pending_arrivals.insert(pending_arrivals.size(), a);
  endfunction

  function automatic void write_shadow(logic [2:0] idx, logic [30:0] val);
    case (idx)
      REG_ENABLE: enable_q = val[0];
      REG_MIN:    min_q = val;
      REG_MAX:    max_q = val;
      REG_THR:    thr_q = val[15:0];
      REG_UP:     up_q = val[15:0];
      REG_DOWN:   down_q = val[15:0];
      REG_STEPS:  steps_q = val[7:0];
      REG_START:  rate_q = val;
      default: ;
    endcase
  endfunction

  // Compute the report one arrival produces and advance the predictor state
  function automatic rate_report_t predict_rate(arrival_t a);
    rate_report_t r;
    int unsigned win, first, n;
    logic [63:0] fps [WinCap];
    logic [63:0] sum, mean, ssq, var_v, lim, want, d, cur, diff;
    logic [31:0] g;
    r.rate_changed = 1'b0;
    n = 0;
    sum = 0;
    ssq = 0;
    if (!enable_q) r.outcome = OUT_DISABLED;
    else if (a.packet_bytes == 0) r.outcome = OUT_ZERO;
    else begin
      win = (steps_q > 10) ? steps_q : 10;
      if (win > WinCap) win = WinCap;
      stamp_ring[ring_head] = a.arrival_ms;
      ring_head = (ring_head + 1) % WinCap;
      stamp_count++;
      if (stamp_count > win) stamp_count = win;
      r.outcome = OUT_LITTLE;
      if (stamp_count >= 2) begin
        first = (ring_head + WinCap - stamp_count) % WinCap;
        for (int i = 1; i < stamp_count; i++) begin
          g = stamp_ring[(first + i) % WinCap] - stamp_ring[(first + i - 1) % WinCap];
          if (g >= 2 && g <= 9999) begin
            fps[n] = 64'd65536000 / g;
            sum += fps[n];
            n++;
          end
        end
        if (n >= 3) begin
          mean = sum / n;
          for (int i = 0; i < n; i++) begin
            d = (fps[i] >= mean) ? fps[i] - mean : mean - fps[i];
            ssq += d * d;
          end
          var_v = ssq / n;
          lim = (64'(thr_q) * mean) >> 16;
          want = rate_q;
          if (var_v > lim * lim) begin
            r.outcome = OUT_UNSTABLE;
            want = (64'(rate_q) * down_q) >> 14;
            if (want < min_q) want = min_q;
            run_q = 0;
          end else begin
            r.outcome = OUT_STABLE;
            if (run_q < 255) run_q++;
            if (run_q >= steps_q) begin
              want = (64'(rate_q) * up_q) >> 14;
              if (want > max_q) want = max_q;
              run_q = 0;
            end
          end
          if (want < min_q) want = min_q;
          if (want > max_q) want = max_q;
          cur = rate_q;
          diff = (want >= cur) ? want - cur : cur - want;
          if (diff * 20 > cur) begin
            rate_q = want[30:0];
            r.rate_changed = 1'b1;
          end
        end
      end
    end
    r.rate_now = rate_q;
    return r;
  endfunction

  // Queue a well-formed frame stream: steady pacing with optional jitter
  task automatic queue_stream(int count, int pace, int jitter, logic [31:0] base);
    logic [31:0] t;
    t = base;
    for (int i = 0; i < count; i++) begin
      t = t + pace + ((jitter > 0) ? $urandom_range(0, jitter) : 0);
      add_arrival(t, 24'($urandom_range(1, 24'hFFFFFF)));
    end
    last_stamp = t;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    write_shadow(idx, val);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Hold until the driver has drained its queue and every report has come
  task automatic drain();
    while (pending_arrivals.size() != 0 || in_valid || expected_reports.size() != 0)
      @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Drive arrivals from the queue with a random gap before each one
  always @(posedge clk_i) begin
    if (in_valid && in_ready) begin
      rate_report_t p;
      p = predict_rate('{arrival_ms_i, packet_bytes_i});
      expected_reports.insert(expected_reports.size(), p);
      in_valid <= 1'b0;
      send_wait <= $urandom_range(0, 17);
    end else if (!in_valid && rst_ni) begin
      if (arm_dwell) begin
        if (expected_reports.size() == 0) arm_dwell <= 1'b0;
      end else if (send_wait > 0) send_wait <= send_wait - 1;
      else if (pending_arrivals.size() != 0) begin
        arrival_t a;
        a = pending_arrivals[0];
        pending_arrivals.delete(0);
        arrival_ms_i <= a.arrival_ms;
        packet_bytes_i <= a.packet_bytes;
        in_valid <= 1'b1;
      end
    end
  end

  // Check reports against predictions and stall the output at random
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected report rate_now=%0d", rate_now_o);
        failures++;
      end else begin
        rate_report_t e;
        e = expected_reports[0];
        expected_reports.delete(0);
        if (rate_now_o !== e.rate_now) begin
          $error("rate_now expected %0d actual %0d", e.rate_now, rate_now_o);
          failures++;
        end
        if (rate_changed_o !== e.rate_changed) begin
          $error("rate_changed expected %0d actual %0d", e.rate_changed, rate_changed_o);
          failures++;
        end
        if (outcome_o !== e.outcome) begin
          $error("outcome expected %0d actual %0d", e.outcome, outcome_o);
          failures++;
        end
      end
      out_ready <= 1'b0;
      recv_wait <= $urandom_range(0, 17);
    end else if (!out_ready && rst_ni) begin
      if (recv_wait > 0) recv_wait <= recv_wait - 1;
      else out_ready <= 1'b1;
    end
  end

  // Abort on a hung run
  always @(posedge clk_i) begin
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int pace;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    arrival_ms_i = '0;
    packet_bytes_i = '0;
    cfg_we = 1'b0;
    cfg_index = REG_ENABLE;
    cfg_data = '0;
    failures = 0;
    cycle_count = 0;
    send_wait = 0;
    recv_wait = 0;
    arm_dwell = 1'b0;
    last_stamp = '0;
    enable_q = 1'b1;
    min_q = 500000;
    max_q = 8000000;
    thr_q = 13107;
    up_q = 18022;
    down_q = 13107;
    steps_q = 10;
    rate_q = 2000000;
    run_q = 0;
    stamp_count = 0;
    ring_head = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero packet, field extremes, wraparound gaps, invalid gaps
    add_arrival(32'd0, 24'd0);
    add_arrival(32'hFFFFFFF0, 24'hFFFFFF);
    add_arrival(32'hFFFFFFFF, 24'd1);
    add_arrival(32'd30, 24'd5);
    add_arrival(32'd10029, 24'd5);
    add_arrival(32'd10031, 24'd5);
    add_arrival(32'd20030, 24'd5);
    queue_stream(12, 33, 0, 32'd20030);
    queue_stream(6, 10, 60, 32'd30000);
    drain();

    // Disabled arrivals report OUT_DISABLED and do not enter the window
    write_reg(REG_ENABLE, 31'd0);
    add_arrival(32'hA5A5A5A5, 24'h5A5A5A);
    add_arrival(32'h5A5A5A5A, 24'd0);
    drain();
    write_reg(REG_ENABLE, 31'd1);

    // Sweep settings: defaults-like, extremes, inverted bounds, zero steps
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_STEPS, 31'd0);
          write_reg(REG_UP, 31'hFFFF);
          write_reg(REG_START, 31'd1000000);
        end
        1: begin
          write_reg(REG_MIN, 31'h7FFFFFFF);
          write_reg(REG_MAX, 31'd0);
          write_reg(REG_THR, 31'd0);
        end
        2: begin
          write_reg(REG_MIN, 31'd0);
          write_reg(REG_MAX, 31'h7FFFFFFF);
          write_reg(REG_THR, 31'hFFFF);
          write_reg(REG_DOWN, 31'd0);
          write_reg(REG_STEPS, 31'd255);
          write_reg(REG_START, 31'h7FFFFFFF);
        end
        3: begin
          write_reg(REG_STEPS, 31'd3);
          write_reg(REG_THR, 31'd2000);
          write_reg(REG_DOWN, 31'hFFFF);
          write_reg(REG_UP, 31'd0);
          write_reg(REG_START, 31'd0);
        end
        4: begin
          write_reg(REG_STEPS, 31'd20);
          write_reg(REG_MIN, 31'd100000);
          write_reg(REG_MAX, 31'd50000000);
          write_reg(REG_UP, 31'd20000);
          write_reg(REG_DOWN, 31'd12000);
          write_reg(REG_THR, 31'd6000);
          write_reg(REG_START, 31'd3000000);
        end
        5: write_reg(REG_STEPS, 31'd12);
        6: begin
          write_reg(REG_STEPS, 31'd1);
          write_reg(REG_THR, 31'($urandom_range(0, 65535)));
          write_reg(REG_UP, 31'($urandom_range(0, 65535)));
          write_reg(REG_DOWN, 31'($urandom_range(0, 65535)));
          write_reg(REG_START, 31'($urandom));
          write_reg(REG_MIN, 31'($urandom_range(0, 1000000)));
          write_reg(REG_MAX, 31'($urandom));
        end
        default: begin
          write_reg(REG_STEPS, 31'd10);
          write_reg(REG_THR, 31'd13107);
          write_reg(REG_UP, 31'd18022);
          write_reg(REG_DOWN, 31'd13107);
          write_reg(REG_MIN, 31'd500000);
          write_reg(REG_MAX, 31'd8000000);
          write_reg(REG_START, 31'd2000000);
        end
      endcase
      // Mostly paced streams with random jitter, some noise and skipped packets
      pace = $urandom_range(20, 120);
      for (int k = 0; k < 130; k++) begin
        case ($urandom_range(0, 9))
          0: add_arrival(32'($urandom), 24'($urandom));
          1: add_arrival(32'($urandom), 24'd0);
          default: begin
            queue_stream(1, pace, ($urandom_range(0, 3) == 0) ? pace / 2 : 0,
                         last_stamp);
          end
        endcase
      end
      // Let the stream keep some continuity within a phase
      if (phase == 4) arm_dwell <= 1'b1;
      drain();
    end

    if (failures == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
